[sv/pdf_pkg.sv]
// Package: shared types, breakpoint tables and codes for the PVT derating core.
package pdf_pkg;

  // Table geometry and datapath widths
  localparam int TABLE_SLOTS = 16;
  localparam int IDX_W       = 4;
  localparam int X_W         = 13;
  localparam int YT_W        = 17;
  localparam int FACT_W      = 18;
  localparam int SPAN_W      = 14;
  localparam int Q_W         = 17;
  localparam int DIVD_W      = Q_W + SPAN_W;

  // Default table lengths
  localparam int VOLT_POINTS_DEF = 7;
  localparam int TEMP_POINTS_DEF = 15;

  typedef logic signed [X_W-1:0] x_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [FACT_W-1:0]     fact_t;
  typedef logic [YT_W-1:0]       ytab_t;

  typedef enum logic [1:0] {
    CMD_VOLT = 2'd0,
    CMD_TEMP = 2'd1,
    CMD_PROC = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_VOLT   = 2'd1,
    ERR_TEMP   = 2'd2,
    ERR_CORNER = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MUL,
    ST_DIV,
    ST_WB
  } st_t;

  // Process corners and their factors (Q2.16)
  localparam logic [2:0] CORNER_SLOW = 3'd1;
  localparam logic [2:0] CORNER_TYP  = 3'd2;
  localparam logic [2:0] CORNER_FAST = 3'd3;
  localparam fact_t PROC_SLOW_FACT = 18'd76955;
  localparam fact_t PROC_TYP_FACT  = 18'd65536;
  localparam fact_t PROC_FAST_FACT = 18'd57419;

  // Breakpoints: millivolts, and sixteenths of a degree C
  localparam x_t VOLT_X [TABLE_SLOTS] = '{
    13'sd1080, 13'sd1120, 13'sd1160, 13'sd1200, 13'sd1240, 13'sd1280, 13'sd1320,
    13'sd1320, 13'sd1320, 13'sd1320, 13'sd1320, 13'sd1320, 13'sd1320, 13'sd1320,
    13'sd1320, 13'sd1320};
  localparam ytab_t VOLT_Y [TABLE_SLOTS] = '{
    17'd73502, 17'd70473, 17'd67840, 17'd65536, 17'd63470, 17'd61608, 17'd59931,
    17'd59931, 17'd59931, 17'd59931, 17'd59931, 17'd59931, 17'd59931, 17'd59931,
    17'd59931, 17'd59931};
  localparam x_t TEMP_X [TABLE_SLOTS] = '{
    -13'sd320, -13'sd240, 13'sd0, 13'sd240, 13'sd400, 13'sd560, 13'sd720,
    13'sd880, 13'sd1040, 13'sd1200, 13'sd1360, 13'sd1520, 13'sd1680, 13'sd1840,
    13'sd2000, 13'sd2000};
  localparam ytab_t TEMP_Y [TABLE_SLOTS] = '{
    17'd58818, 17'd60131, 17'd62150, 17'd64174, 17'd65536, 17'd66867, 17'd68193,
    17'd69588, 17'd70974, 17'd72340, 17'd73671, 17'd74989, 17'd76321, 17'd77619,
    17'd78969, 17'd78969};

  // Result of the breakpoint walk
  typedef struct packed {
    logic done;
    logic exact;
    idx_t idx;
  } seg_rsp_t;

  // Result of the divider
  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

  function automatic x_t tbl_x(input logic sel_temp, input idx_t i);
    return sel_temp ? TEMP_X[i] : VOLT_X[i];
  endfunction

  function automatic ytab_t tbl_y(input logic sel_temp, input idx_t i);
    return sel_temp ? TEMP_Y[i] : VOLT_Y[i];
  endfunction

  // Last usable table index for a given point count, kept within 1..15
  function automatic idx_t last_idx(input int n);
    if (n - 1 < 1) begin
      return idx_t'(1);
    end
    if (n - 1 > TABLE_SLOTS - 1) begin
      return idx_t'(TABLE_SLOTS - 1);
    end
    return idx_t'(n - 1);
  endfunction

endpackage

[sv/pdf_seg.sv]
// Segment search: walks the breakpoint table with one shared compare per cycle.
module pdf_seg import pdf_pkg::*; #(
  parameter int VOLT_POINTS = VOLT_POINTS_DEF,
  parameter int TEMP_POINTS = TEMP_POINTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     start_sel_temp,
  input  x_t       start_value,
  output seg_rsp_t rsp
);

  localparam idx_t VOLT_LAST = last_idx(VOLT_POINTS);
  localparam idx_t TEMP_LAST = last_idx(TEMP_POINTS);

  logic busy_r;
  logic sel_r;
  x_t   val_r;
  idx_t idx_r;
  idx_t last;
  x_t   x_cur;
  logic adv;

  // Shared compare against the current breakpoint
  always_comb begin
    last  = sel_r ? TEMP_LAST : VOLT_LAST;
    x_cur = tbl_x(sel_r, idx_r);
    adv   = busy_r && (idx_r < last) && (x_cur < val_r);
  end

  assign rsp.done  = busy_r && !adv;
  assign rsp.exact = (x_cur == val_r) || (idx_r == '0);
  assign rsp.idx   = idx_r;

  // Walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && !adv) begin
      busy_r <= 1'b0;
    end
  end

  // Walk index and operands
  always_ff @(posedge clk) begin
    if (start) begin
      idx_r <= '0;
      sel_r <= start_sel_temp;
      val_r <= start_value;
    end else if (adv) begin
      idx_r <= idx_r + idx_t'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= last))
    else $error("segment index past last breakpoint");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("segment search restarted while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp.done && !start) |=> !busy_r)
    else $error("segment search kept running after done");
`endif

endmodule

[sv/pdf_div.sv]
// Restoring divider: one quotient bit per cycle for the interpolation step.
module pdf_div import pdf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [SPAN_W-1:0] divisor,
  output div_rsp_t          rsp
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SPAN_W-1:0] rem_r;
  logic [SPAN_W-1:0] dvs_r;
  logic [Q_W-1:0]    quo_r;
  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   diff;
  logic              ge;

  // Trial subtract
  always_comb begin
    trial = {rem_r, quo_r[Q_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = !diff[SPAN_W];
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift register (low dividend bits shift out as quotient fills)
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DIVD_W-1:Q_W];
      quo_r <= dividend[Q_W-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
      quo_r <= {quo_r[Q_W-2:0], ge};
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("divider done without a finished run");
`endif

endmodule

[sv/pvt_derating_factor_interp_core.sv]
// Top level: PVT derating factor sequencer, factor registers and result register.
// Sequence: process, unused and out-of-range commands go from the input transfer straight
// to write-back; an exact breakpoint hit passes through the table walk first, and an
// interpolation through the walk, a multiply step and the divider. The one-compare-per-
// cycle table walk and the 17-step restoring divider set the pace; the divider dominates interpolation.
// Throughput: one item at a time; the next transfer is taken the cycle after the result
// is loaded. Synchronous active-low reset clears all three factors and the result valid.
module pvt_derating_factor_interp_core import pdf_pkg::*; #(
  parameter int VOLT_POINTS = VOLT_POINTS_DEF,
  parameter int TEMP_POINTS = TEMP_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [11:0]       in_voltage_mv,
  input  logic signed [12:0] in_temperature_q4,
  input  logic [2:0]        in_process_corner,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_error_code,
  output logic [17:0]       out_voltage_factor,
  output logic [17:0]       out_temperature_factor,
  output logic [17:0]       out_process_factor
);

  localparam idx_t VOLT_LAST = last_idx(VOLT_POINTS);
  localparam idx_t TEMP_LAST = last_idx(TEMP_POINTS);

  st_t      state_r, state_nxt;
  cmd_t     cmd_r;
  err_t     err_r;
  err_t     out_err_r;
  logic     sel_r;
  x_t       val_r;
  idx_t     idx_r;
  fact_t    res_r;
  logic     neg_r;
  ytab_t    base_r;
  logic     out_valid_r;
  fact_t    volt_factor_r, temp_factor_r, proc_factor_r;

  logic     accept;
  cmd_t     in_cmd;
  logic     in_sel;
  x_t       in_x;
  logic     out_range;
  logic     searching;
  err_t     in_err;
  fact_t    corner_fact;
  logic     seg_start;
  logic     div_start;
  logic     wb_go;
  seg_rsp_t seg_rsp;
  div_rsp_t div_rsp;

  // Interpolation operands
  idx_t                   idx_lo;
  x_t                     x_hi, x_lo;
  ytab_t                  y_hi, y_lo;
  logic signed [SPAN_W-1:0] span_s, dx_s;
  logic signed [YT_W:0]   dy;
  ytab_t                  dy_mag;
  logic [DIVD_W-1:0]      prod;
  logic [DIVD_W-1:0]      dividend;
  logic signed [YT_W+1:0] sum;
  fact_t                  interp_res;

  // Input decode and range check
  always_comb begin
    in_cmd    = cmd_t'(in_command);
    in_sel    = (in_cmd == CMD_TEMP);
    in_x      = in_sel ? in_temperature_q4 : $signed({1'b0, in_voltage_mv});
    out_range = (in_x < tbl_x(in_sel, '0)) ||
                (in_x > tbl_x(in_sel, in_sel ? TEMP_LAST : VOLT_LAST));
    searching = ((in_cmd == CMD_VOLT) || (in_cmd == CMD_TEMP)) && !out_range;
    unique case (in_process_corner)
      CORNER_SLOW: corner_fact = PROC_SLOW_FACT;
      CORNER_TYP:  corner_fact = PROC_TYP_FACT;
      CORNER_FAST: corner_fact = PROC_FAST_FACT;
      default:     corner_fact = '0;
    endcase
    unique case (in_cmd)
      CMD_VOLT: in_err = out_range ? ERR_VOLT : ERR_OK;
      CMD_TEMP: in_err = out_range ? ERR_TEMP : ERR_OK;
      CMD_PROC: in_err = ((in_process_corner == CORNER_SLOW) ||
                          (in_process_corner == CORNER_TYP)  ||
                          (in_process_corner == CORNER_FAST)) ? ERR_OK : ERR_CORNER;
      CMD_NONE: in_err = ERR_OK;
      default:  in_err = ERR_OK;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = searching ? ST_SEARCH : ST_WB;
        end
      end
      ST_SEARCH: begin
        if (seg_rsp.done) begin
          state_nxt = seg_rsp.exact ? ST_WB : ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        if (wb_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs; input held off while in reset
  always_comb begin
    in_stall  = !rst_n || (state_r != ST_IDLE);
    accept    = in_valid && !in_stall;
    seg_start = accept && searching;
    div_start = (state_r == ST_MUL);
    wb_go     = (state_r == ST_WB) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  pdf_seg #(
    .VOLT_POINTS (VOLT_POINTS),
    .TEMP_POINTS (TEMP_POINTS)
  ) u_seg (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (seg_start),
    .start_sel_temp (in_sel),
    .start_value    (in_x),
    .rsp            (seg_rsp)
  );

  // Segment operands, |dy| * dx and rounding offset feed the divider
  always_comb begin
    idx_lo   = idx_r - idx_t'(1);
    x_hi     = tbl_x(sel_r, idx_r);
    x_lo     = tbl_x(sel_r, idx_lo);
    y_hi     = tbl_y(sel_r, idx_r);
    y_lo     = tbl_y(sel_r, idx_lo);
    span_s   = SPAN_W'(x_hi) - SPAN_W'(x_lo);
    dx_s     = SPAN_W'(val_r) - SPAN_W'(x_lo);
    dy       = $signed({1'b0, y_hi}) - $signed({1'b0, y_lo});
    dy_mag   = dy[YT_W] ? YT_W'(-dy) : dy[YT_W-1:0];
    prod     = DIVD_W'(dy_mag) * DIVD_W'($unsigned(dx_s));
    dividend = prod + DIVD_W'($unsigned(span_s) >> 1);
  end

  pdf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  ($unsigned(span_s)),
    .rsp      (div_rsp)
  );

  // Apply the rounded quotient to the lower point; clamp below zero
  always_comb begin
    sum = neg_r ? ($signed({2'b00, base_r}) - $signed({2'b00, div_rsp.quot}))
                : ($signed({2'b00, base_r}) + $signed({2'b00, div_rsp.quot}));
    interp_res = sum[YT_W+1] ? '0 : sum[FACT_W-1:0];
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      err_r <= in_err;
      sel_r <= in_sel;
      val_r <= in_x;
      res_r <= corner_fact;
    end
    if ((state_r == ST_SEARCH) && seg_rsp.done) begin
      idx_r <= seg_rsp.idx;
      res_r <= FACT_W'(tbl_y(sel_r, seg_rsp.idx));
    end
    if (state_r == ST_MUL) begin
      neg_r  <= dy[YT_W];
      base_r <= y_lo;
    end
    if ((state_r == ST_DIV) && div_rsp.done) begin
      res_r <= interp_res;
    end
  end

  // Stored factors double as the result payload; they only move on reset or an error-free result load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_factor_r <= '0;
      temp_factor_r <= '0;
      proc_factor_r <= '0;
      out_valid_r   <= 1'b0;
      out_err_r     <= ERR_OK;
    end else begin
      if (wb_go) begin
        out_valid_r <= 1'b1;
        out_err_r   <= err_r;
        if (err_r == ERR_OK) begin
          unique case (cmd_r)
            CMD_VOLT: volt_factor_r <= res_r;
            CMD_TEMP: temp_factor_r <= res_r;
            CMD_PROC: proc_factor_r <= res_r;
            CMD_NONE: ;
            default:  ;
          endcase
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_error_code         = out_err_r;
  assign out_voltage_factor     = volt_factor_r;
  assign out_temperature_factor = temp_factor_r;
  assign out_process_factor     = proc_factor_r;

`ifndef NO_ASSERTIONS
  a_seg_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    seg_rsp.done |-> (state_r == ST_SEARCH))
    else $error("segment result outside search state");
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider result outside divide state");
  a_error_keeps_factors: assert property (@(posedge clk) disable iff (!rst_n)
    (wb_go && (err_r != ERR_OK)) |=>
      ((volt_factor_r == $past(volt_factor_r)) &&
       (temp_factor_r == $past(temp_factor_r)) &&
       (proc_factor_r == $past(proc_factor_r))))
    else $error("factor changed on an error result");
  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && (state_r == ST_WB)) |=> (state_r == ST_WB))
    else $error("result loaded over a pending transfer");
`endif

endmodule
